/* hw/rtl/mtf_pkg.sv */
// Shared widths, reset values and link types for the move-to-front encoder.
`timescale 1ns / 1ps

package mtf_pkg;

    localparam int MTF_MAX_SYMBOLS = 256;
    localparam int SYMBOL_W        = 9;
    localparam int POSITION_W      = 8;
    localparam int LIST_SIZE_W     = 9;

    localparam logic [LIST_SIZE_W-1:0] LIST_SIZE_RST = 9'd256;

    // Per-cell control: identity reload and token arrival from the left neighbor.
    typedef struct packed {
        logic init;
        logic carry_vld;
    } t_cell_ctl;

endpackage

/* hw/rtl/mtf_cell.sv */
// One list entry of the move-to-front chain, with its carry register to the next cell.
`timescale 1ns / 1ps

module mtf_cell import mtf_pkg::*; #(
    parameter int                 SYM_W      = 9,
    parameter logic [SYM_W-1:0]   INIT_VALUE = '0
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [SYM_W-1:0]  i_carry,
    input  logic [SYM_W-1:0]  i_sym,
    output logic              o_carry_vld,
    output logic [SYM_W-1:0]  o_carry,
    output logic              o_hit
);

    logic [SYM_W-1:0] r_entry;
    logic [SYM_W-1:0] r_carry;
    logic             r_carry_vld;

    assign o_hit       = i_ctl.carry_vld && (r_entry == i_sym);
    assign o_carry     = r_carry;
    assign o_carry_vld = r_carry_vld;

    // The incoming value always takes this place; the old entry moves right
    // unless it is the symbol itself, which ends the shift here.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.init) begin
            r_entry     <= INIT_VALUE;
            r_carry_vld <= 1'b0;
        end else if (i_ctl.carry_vld) begin
            r_entry     <= i_carry;
            r_carry     <= r_entry;
            r_carry_vld <= !o_hit;
        end else begin
            r_carry_vld <= 1'b0;
        end
    end

endmodule

/* hw/rtl/move_to_front_encoder.sv */
// Move-to-front encoder: a chain of list cells that a shift token walks one cell per cycle.
// An out-of-range symbol sets its result register when it is accepted; a valid symbol
// found at position p sets it once the token reaches cell p and that cell reports a hit.
// One transaction at a time: a valid symbol holds off new input until its search ends,
// with the token stepping one cell per cycle until it meets the symbol.
// Reset is synchronous and active low: the list returns to 1, 2, 3 ... and list_size to 256.
`timescale 1ns / 1ps

module move_to_front_encoder import mtf_pkg::*; #(
    parameter int MAX_SYMBOLS = MTF_MAX_SYMBOLS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SYMBOL_W-1:0]    i_symbol_in,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [POSITION_W-1:0]  o_position_out,
    output logic                   o_bad_symbol,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [LIST_SIZE_W-1:0] i_cfg_data
);

    localparam int SYM_W = $clog2(MAX_SYMBOLS + 1);
    localparam int POS_W = $clog2(MAX_SYMBOLS);

    logic                   r_busy;
    logic [POS_W-1:0]       r_pos;
    logic [SYMBOL_W-1:0]    r_sym;
    logic                   r_out_vld;
    logic [POSITION_W-1:0]  r_position;
    logic                   r_bad;
    logic [LIST_SIZE_W-1:0] r_list_size;

    logic                   in_fire;
    logic                   cfg_fire;
    logic                   sym_ok;
    logic                   hit_now;
    logic                   head_vld;
    logic [SYM_W-1:0]       sym_cell;

    logic [MAX_SYMBOLS-1:0] cell_in_vld;
    logic [MAX_SYMBOLS-1:0] cell_out_vld;
    logic [MAX_SYMBOLS-1:0] hit_vec;
    logic [SYM_W-1:0]       cell_in_carry  [MAX_SYMBOLS];
    logic [SYM_W-1:0]       cell_out_carry [MAX_SYMBOLS];
    t_cell_ctl              cell_ctl       [MAX_SYMBOLS];

    // A pending configuration write holds off new symbols so the size and list change first.
    assign o_in_stall  = r_busy || (r_out_vld && i_out_stall) || i_cfg_valid;
    assign o_cfg_ready = !r_busy;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    // A zero size still admits symbol 1, and sizes beyond the list saturate.
    assign sym_ok = (i_symbol_in != '0)
                 && ((i_symbol_in <= r_list_size) || (i_symbol_in == SYMBOL_W'(1)))
                 && (32'(i_symbol_in) <= 32'(MAX_SYMBOLS));

    assign head_vld = r_busy && (r_pos == '0);
    assign sym_cell = SYM_W'(r_sym);
    // Only the cell holding the token can hit, and that cell sits at r_pos.
    assign hit_now  = hit_vec[r_pos];

    generate
        for (genvar k = 0; k < MAX_SYMBOLS; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign cell_in_vld[k]   = head_vld;
                assign cell_in_carry[k] = sym_cell;
            end else begin : g_body
                assign cell_in_vld[k]   = cell_out_vld[k-1];
                assign cell_in_carry[k] = cell_out_carry[k-1];
            end

            assign cell_ctl[k] = '{init: cfg_fire, carry_vld: cell_in_vld[k]};

            mtf_cell #(
                .SYM_W      (SYM_W),
                .INIT_VALUE (SYM_W'(k + 1))
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (cell_ctl[k]),
                .i_carry     (cell_in_carry[k]),
                .i_sym       (sym_cell),
                .o_carry_vld (cell_out_vld[k]),
                .o_carry     (cell_out_carry[k]),
                .o_hit       (hit_vec[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_list_size <= LIST_SIZE_RST;
        end else begin
            if (cfg_fire) begin
                r_list_size <= i_cfg_data;
            end
            if (r_out_vld && !i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            if (in_fire) begin
                if (sym_ok) begin
                    r_busy <= 1'b1;
                    r_pos  <= '0;
                    r_sym  <= i_symbol_in;
                end else begin
                    r_out_vld  <= 1'b1;
                    r_position <= '0;
                    r_bad      <= 1'b1;
                end
            end
            if (r_busy) begin
                if (hit_now) begin
                    r_busy     <= 1'b0;
                    r_out_vld  <= 1'b1;
                    r_position <= POSITION_W'(r_pos);
                    r_bad      <= 1'b0;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_position_out = r_position;
    assign o_bad_symbol   = r_bad;

`ifndef ASSERT_OFF
    // At most one cell of the chain holds the shift token.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(cell_in_vld))
        else $error("more than one cell holds the shift token");

    // The token only exists while a transaction is in flight.
    a_token_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cell_in_vld != '0) |-> r_busy)
        else $error("shift token present while idle");

    // A result is never pending while the chain is still working.
    a_no_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_out_vld))
        else $error("result pending during a search");

    // A valid symbol starts the token at the head cell in the next cycle.
    a_start_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && sym_ok) |=> cell_in_vld[0])
        else $error("accepted symbol did not enter the head cell");
`endif

endmodule

/* tb/move_to_front_checker.sv */
// Checker for the move-to-front encoder: tracks the symbol list and compares every result.
`timescale 1ns / 1ps

module move_to_front_checker import mtf_pkg::*; #(
    parameter int MAX_SYMBOLS = MTF_MAX_SYMBOLS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [SYMBOL_W-1:0]    i_symbol_in,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [POSITION_W-1:0]  i_position_out,
    input  logic                   i_bad_symbol,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic [LIST_SIZE_W-1:0] i_cfg_data,
    output int                     o_pending,
    output int                     o_fail_count
);

    typedef struct packed {
        logic [POSITION_W-1:0] position;
        logic                  bad_symbol;
    } t_mtf_result;

    logic [SYMBOL_W-1:0]    symbol_list [MAX_SYMBOLS];
    logic [LIST_SIZE_W-1:0] list_size;
    t_mtf_result            position_q [$];
    int                     fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic restore_identity();
        for (int k = 0; k < MAX_SYMBOLS; k++) begin
            symbol_list[k] = SYMBOL_W'(k + 1);
        end
    endtask

    task automatic report_mismatch(input string detail);
        $display("t=%0t: %s", $time, detail);
        fail_count++;
    endtask

    // Looks the symbol up in the list, moves it to the front and returns its old position.
    task automatic encode_symbol(input logic [SYMBOL_W-1:0] sym, output t_mtf_result res);
        int  n;
        int  pos;
        bit  found;
        n     = int'(list_size);
        pos   = 0;
        found = 1'b0;
        res   = '0;
        if (n < 1) n = 1;
        if (n > MAX_SYMBOLS) n = MAX_SYMBOLS;
        if (sym >= 1 && int'(sym) <= n) begin
            for (int k = 0; k < n; k++) begin
                if (!found && symbol_list[k] == sym) begin
                    pos   = k;
                    found = 1'b1;
                end
            end
        end
        if (!found) begin
            // The list stays as it was for a symbol outside the active range.
            res.bad_symbol = 1'b1;
        end else begin
            for (int k = pos; k > 0; k--) begin
                symbol_list[k] = symbol_list[k-1];
            end
            symbol_list[0] = sym;
            res.position   = POSITION_W'(pos);
        end
    endtask

    always @(posedge i_clk) begin
        t_mtf_result want;
        t_mtf_result fresh;
        if (!i_rst_n) begin
            list_size = LIST_SIZE_RST;
            restore_identity();
            position_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                list_size = i_cfg_data;
                restore_identity();
            end
            // Results are checked before new symbols are predicted in the same cycle.
            if (i_out_valid && !i_out_stall) begin
                if (position_q.size() == 0) begin
                    report_mismatch($sformatf("result with nothing pending: position %0d bad %0b",
                                              i_position_out, i_bad_symbol));
                end else begin
                    want = position_q.pop_front();
                    if (i_position_out !== want.position)
                        report_mismatch($sformatf("position_out got %0d, expected %0d",
                                                  i_position_out, want.position));
                    if (i_bad_symbol !== want.bad_symbol)
                        report_mismatch($sformatf("bad_symbol got %0b, expected %0b",
                                                  i_bad_symbol, want.bad_symbol));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                encode_symbol(i_symbol_in, fresh);
                position_q.insert(position_q.size(), fresh);
            end
        end
        o_pending <= position_q.size();
    end

endmodule

/* tb/move_to_front_encoder_tb.sv */
// Testbench top for the move-to-front encoder: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module move_to_front_encoder_tb import mtf_pkg::*;;

    localparam int IDLE_LIMIT      = 2000;
    localparam int HOLD_CYCLES     = 200;
    localparam int HOLD_AFTER      = 120;
    localparam int SETTLE_CYCLES   = 20;
    localparam int ITEMS_PER_PHASE = 50;
    localparam int PHASES          = 10;
    localparam int RECENT_DEPTH    = 4;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    logic [SYMBOL_W-1:0]    i_symbol_in;
    logic                   o_out_valid;
    logic                   i_out_stall;
    logic [POSITION_W-1:0]  o_position_out;
    logic                   o_bad_symbol;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [LIST_SIZE_W-1:0] i_cfg_data;

    int                  pending;
    int                  fail_count;
    int                  items_sent  = 0;
    int                  idle_cycles = 0;
    bit                  quiet       = 1'b0;
    bit                  hold_done   = 1'b0;
    logic [SYMBOL_W-1:0] recent_q [$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    move_to_front_encoder u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_symbol_in    (i_symbol_in),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_position_out (o_position_out),
        .o_bad_symbol   (o_bad_symbol),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data)
    );

    move_to_front_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_symbol_in    (i_symbol_in),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_position_out (o_position_out),
        .i_bad_symbol   (o_bad_symbol),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    task automatic send_symbol(input logic [SYMBOL_W-1:0] sym);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_symbol_in <= sym;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        items_sent++;
        recent_q.insert(recent_q.size(), sym);
        if (recent_q.size() > RECENT_DEPTH) void'(recent_q.pop_front());
    endtask

    // The size register is only written once every pending result has come back.
    task automatic write_list_size(input logic [LIST_SIZE_W-1:0] value);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        recent_q.delete();
    endtask

    // Mostly in-range symbols; recent ones give short positions, a few are pure noise.
    function automatic logic [SYMBOL_W-1:0] pick_symbol(input int active);
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return SYMBOL_W'($urandom_range(0, (1 << SYMBOL_W) - 1));
        if (roll < 5 && recent_q.size() > 0)
            return recent_q[$urandom_range(0, recent_q.size() - 1)];
        return SYMBOL_W'($urandom_range(1, active));
    endfunction

    // Receiver: random stall per transaction, and one long hold-off that backs up the input.
    initial begin
        int gap;
        i_out_stall = 1'b1;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (!hold_done && items_sent >= HOLD_AFTER) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                gap = quiet ? 0 : $urandom_range(0, 6);
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("move_to_front_encoder: mismatch");
        $finish;
    end

    initial begin
        int                     active;
        logic [LIST_SIZE_W-1:0] size_pick;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_symbol_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Size after reset: out-of-range codes, the far end of the list and repeats.
        send_symbol(9'd0);
        send_symbol(9'd511);
        send_symbol(9'd257);
        send_symbol(9'd256);
        send_symbol(9'd256);
        send_symbol(9'd1);
        send_symbol(9'd1);
        send_symbol(9'd128);
        send_symbol(9'd255);
        send_symbol(9'd2);
        send_symbol(9'd170);
        send_symbol(9'd85);

        // A size of zero behaves as a single-symbol list.
        write_list_size(9'd0);
        send_symbol(9'd1);
        send_symbol(9'd1);
        send_symbol(9'd2);
        send_symbol(9'd0);

        // Sizes beyond the list length saturate at the full list.
        write_list_size(9'd511);
        send_symbol(9'd256);
        send_symbol(9'd257);

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       size_pick = 9'd1;
                1:       size_pick = 9'd2;
                2:       size_pick = 9'd3;
                3:       size_pick = 9'd8;
                4:       size_pick = 9'd257;
                5:       size_pick = 9'd16;
                6:       size_pick = 9'd0;
                7:       size_pick = 9'd5;
                8:       size_pick = 9'd256;
                default: size_pick = LIST_SIZE_W'($urandom_range(0, (1 << LIST_SIZE_W) - 1));
            endcase
            write_list_size(size_pick);
            active = (size_pick == 0) ? 1 :
                     (size_pick > MTF_MAX_SYMBOLS) ? MTF_MAX_SYMBOLS : int'(size_pick);
            quiet = (phase % 4 == 2);
            repeat (ITEMS_PER_PHASE) send_symbol(pick_symbol(active));
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("move_to_front_encoder: match");
        else
            $display("move_to_front_encoder: mismatch");
        $finish;
    end

endmodule
